FILE: design/rspg_pkg.sv
// ----------------------------------------------------------------------------
// rspg_pkg
// Shared widths, register indexes and reset values for the ramped stepper
// pulse generator.
// ----------------------------------------------------------------------------
package rspg_pkg;

    localparam int MOTOR_COUNT  = 6;
    localparam int DISABLE_W    = 6;
    localparam int MOTOR_W      = 3;
    localparam int PERIOD_W     = 10;
    localparam int COUNT_W      = 10;
    localparam int TICK_W       = 16;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_START_HALF_PERIOD    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MIN_HALF_PERIOD      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_QUARTER_PULSES       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_QUARTER_ACCEL_PULSES = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_PULSES          = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_HALF_ACCEL_PULSES    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_TICKS         = 3'd6;

    localparam logic [PERIOD_W-1:0] RST_START_HALF_PERIOD    = 10'd400;
    localparam logic [PERIOD_W-1:0] RST_MIN_HALF_PERIOD      = 10'd300;
    localparam logic [COUNT_W-1:0]  RST_QUARTER_PULSES       = 10'd400;
    localparam logic [COUNT_W-1:0]  RST_QUARTER_ACCEL_PULSES = 10'd320;
    localparam logic [COUNT_W-1:0]  RST_HALF_PULSES          = 10'd800;
    localparam logic [COUNT_W-1:0]  RST_HALF_ACCEL_PULSES    = 10'd680;
    localparam logic [TICK_W-1:0]   RST_SETTLE_TICKS         = 16'd1000;

    localparam logic [DISABLE_W-1:0] ALL_DISABLED = {DISABLE_W{1'b1}};

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;

    function automatic logic [DISABLE_W-1:0] motor_bit(input logic [MOTOR_W-1:0] m);
        logic [DISABLE_W-1:0] b;
        b = '0;
        if ((int'(m) < MOTOR_COUNT) && (int'(m) < DISABLE_W))
        begin
            b[m[$clog2(DISABLE_W)-1:0]] = 1'b1;
        end
        return b;
    endfunction

endpackage

FILE: design/ramped_stepper_pulse_generator_core.sv
// ----------------------------------------------------------------------------
// ramped_stepper_pulse_generator_core
// Stepper move sequencer: settle, ramped step pulses on a shared line,
// final settle, then disable of the selected motor.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. The move state advances at the
// edge that accepts an item and the result is held in an output register,
// visible on the next cycle. An item can be accepted in every cycle; in_ready
// drops only while the output register holds a result that out_ready has not
// yet taken. Configuration writes take effect at once, one register per cycle.
module ramped_stepper_pulse_generator_core
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               cfg_write,
    input  logic [rspg_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [rspg_pkg::CFG_DATA_W-1:0]    cfg_data,

    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               cmd,
    input  logic [rspg_pkg::MOTOR_W-1:0]       motor,
    input  logic                               direction,
    input  logic                               double_turn,

    output logic                               out_valid,
    input  logic                               out_ready,
    output logic                               step_level,
    output logic                               dir_level,
    output logic [rspg_pkg::DISABLE_W-1:0]     disable_lines,
    output logic                               busy_res,
    output logic                               done_res,
    output logic                               rejected
);

    typedef enum logic [1:0]
    {
        PH_IDLE,
        PH_SETTLE_ON,
        PH_PULSING,
        PH_SETTLE_OFF
    } phase_t;

    logic [rspg_pkg::PERIOD_W-1:0]  start_half_period_reg;
    logic [rspg_pkg::PERIOD_W-1:0]  min_half_period_reg;
    logic [rspg_pkg::COUNT_W-1:0]   quarter_pulses_reg;
    logic [rspg_pkg::COUNT_W-1:0]   quarter_accel_pulses_reg;
    logic [rspg_pkg::COUNT_W-1:0]   half_pulses_reg;
    logic [rspg_pkg::COUNT_W-1:0]   half_accel_pulses_reg;
    logic [rspg_pkg::TICK_W-1:0]    settle_ticks_reg;

    phase_t                         phase_reg,        phase_next;
    logic [rspg_pkg::MOTOR_W-1:0]   motor_sel_reg,    motor_sel_next;
    logic                           dir_reg,          dir_next;
    logic [rspg_pkg::COUNT_W-1:0]   pulse_index_reg,  pulse_index_next;
    logic [rspg_pkg::COUNT_W-1:0]   pulse_total_reg,  pulse_total_next;
    logic [rspg_pkg::COUNT_W-1:0]   accel_limit_reg,  accel_limit_next;
    logic [rspg_pkg::PERIOD_W-1:0]  half_period_reg,  half_period_next;
    logic [rspg_pkg::TICK_W-1:0]    tick_count_reg,   tick_count_next;
    logic                           pulse_level_reg,  pulse_level_next;
    logic [rspg_pkg::DISABLE_W-1:0] disable_reg,      disable_next;
    logic                           done_next;
    logic                           rejected_next;

    logic                           out_valid_reg;
    logic                           step_level_reg;
    logic                           dir_level_reg;
    logic [rspg_pkg::DISABLE_W-1:0] disable_lines_reg;
    logic                           busy_res_reg;
    logic                           done_res_reg;
    logic                           rejected_reg;

    logic                           in_accept;
    logic [rspg_pkg::TICK_W-1:0]    tick_inc;
    logic [rspg_pkg::COUNT_W-1:0]   index_inc;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;
    assign tick_inc  = tick_count_reg + rspg_pkg::TICK_W'(1);
    assign index_inc = pulse_index_reg + rspg_pkg::COUNT_W'(1);

    always_comb
    begin
        phase_next       = phase_reg;
        motor_sel_next   = motor_sel_reg;
        dir_next         = dir_reg;
        pulse_index_next = pulse_index_reg;
        pulse_total_next = pulse_total_reg;
        accel_limit_next = accel_limit_reg;
        half_period_next = half_period_reg;
        tick_count_next  = tick_count_reg;
        pulse_level_next = pulse_level_reg;
        disable_next     = disable_reg;
        done_next        = 1'b0;
        rejected_next    = 1'b0;

        if (cmd == rspg_pkg::CMD_START)
        begin
            if (phase_reg != PH_IDLE)
            begin
                rejected_next = 1'b1;
            end
            else
            begin
                motor_sel_next   = motor;
                dir_next         = direction;
                pulse_total_next = double_turn ? half_pulses_reg : quarter_pulses_reg;
                accel_limit_next = double_turn ? half_accel_pulses_reg
                                               : quarter_accel_pulses_reg;
                half_period_next = start_half_period_reg;
                pulse_index_next = '0;
                tick_count_next  = '0;
                pulse_level_next = 1'b0;
                disable_next     = disable_reg & ~rspg_pkg::motor_bit(motor);
                phase_next       = PH_SETTLE_ON;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                end
                PH_SETTLE_ON:
                begin
                    tick_count_next = tick_inc;
                    if (tick_inc >= settle_ticks_reg)
                    begin
                        tick_count_next = '0;
                        if (pulse_total_reg == '0)
                        begin
                            phase_next = PH_SETTLE_OFF;
                        end
                        else
                        begin
                            phase_next       = PH_PULSING;
                            pulse_level_next = 1'b1;
                        end
                    end
                end
                PH_PULSING:
                begin
                    tick_count_next = tick_inc;
                    if (tick_inc >= rspg_pkg::TICK_W'(half_period_reg))
                    begin
                        tick_count_next = '0;
                        if (pulse_level_reg)
                        begin
                            pulse_level_next = 1'b0;
                        end
                        else
                        begin
                            if ((half_period_reg > min_half_period_reg) &&
                                (pulse_index_reg < accel_limit_reg))
                            begin
                                half_period_next = half_period_reg - rspg_pkg::PERIOD_W'(1);
                            end
                            else if ((half_period_reg < start_half_period_reg) &&
                                     (pulse_index_reg > accel_limit_reg))
                            begin
                                half_period_next = half_period_reg + rspg_pkg::PERIOD_W'(1);
                            end
                            pulse_index_next = index_inc;
                            if (index_inc >= pulse_total_reg)
                            begin
                                phase_next = PH_SETTLE_OFF;
                            end
                            else
                            begin
                                pulse_level_next = 1'b1;
                            end
                        end
                    end
                end
                PH_SETTLE_OFF:
                begin
                    tick_count_next = tick_inc;
                    if (tick_inc >= settle_ticks_reg)
                    begin
                        tick_count_next = '0;
                        disable_next    = disable_reg | rspg_pkg::motor_bit(motor_sel_reg);
                        phase_next      = PH_IDLE;
                        done_next       = 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_half_period_reg    <= rspg_pkg::RST_START_HALF_PERIOD;
            min_half_period_reg      <= rspg_pkg::RST_MIN_HALF_PERIOD;
            quarter_pulses_reg       <= rspg_pkg::RST_QUARTER_PULSES;
            quarter_accel_pulses_reg <= rspg_pkg::RST_QUARTER_ACCEL_PULSES;
            half_pulses_reg          <= rspg_pkg::RST_HALF_PULSES;
            half_accel_pulses_reg    <= rspg_pkg::RST_HALF_ACCEL_PULSES;
            settle_ticks_reg         <= rspg_pkg::RST_SETTLE_TICKS;
            phase_reg                <= PH_IDLE;
            motor_sel_reg            <= '0;
            dir_reg                  <= 1'b0;
            pulse_index_reg          <= '0;
            pulse_total_reg          <= '0;
            accel_limit_reg          <= '0;
            half_period_reg          <= '0;
            tick_count_reg           <= '0;
            pulse_level_reg          <= 1'b0;
            disable_reg              <= rspg_pkg::ALL_DISABLED;
            out_valid_reg            <= 1'b0;
            step_level_reg           <= 1'b0;
            dir_level_reg            <= 1'b0;
            disable_lines_reg        <= rspg_pkg::ALL_DISABLED;
            busy_res_reg             <= 1'b0;
            done_res_reg             <= 1'b0;
            rejected_reg             <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    rspg_pkg::REG_START_HALF_PERIOD:
                        start_half_period_reg <= cfg_data[rspg_pkg::PERIOD_W-1:0];
                    rspg_pkg::REG_MIN_HALF_PERIOD:
                        min_half_period_reg <= cfg_data[rspg_pkg::PERIOD_W-1:0];
                    rspg_pkg::REG_QUARTER_PULSES:
                        quarter_pulses_reg <= cfg_data[rspg_pkg::COUNT_W-1:0];
                    rspg_pkg::REG_QUARTER_ACCEL_PULSES:
                        quarter_accel_pulses_reg <= cfg_data[rspg_pkg::COUNT_W-1:0];
                    rspg_pkg::REG_HALF_PULSES:
                        half_pulses_reg <= cfg_data[rspg_pkg::COUNT_W-1:0];
                    rspg_pkg::REG_HALF_ACCEL_PULSES:
                        half_accel_pulses_reg <= cfg_data[rspg_pkg::COUNT_W-1:0];
                    rspg_pkg::REG_SETTLE_TICKS:
                        settle_ticks_reg <= cfg_data[rspg_pkg::TICK_W-1:0];
                    default:
                    begin
                    end
                endcase
            end

            if (in_accept)
            begin
                phase_reg         <= phase_next;
                motor_sel_reg     <= motor_sel_next;
                dir_reg           <= dir_next;
                pulse_index_reg   <= pulse_index_next;
                pulse_total_reg   <= pulse_total_next;
                accel_limit_reg   <= accel_limit_next;
                half_period_reg   <= half_period_next;
                tick_count_reg    <= tick_count_next;
                pulse_level_reg   <= pulse_level_next;
                disable_reg       <= disable_next;
                out_valid_reg     <= 1'b1;
                step_level_reg    <= pulse_level_next;
                dir_level_reg     <= dir_next;
                disable_lines_reg <= disable_next;
                busy_res_reg      <= (phase_next != PH_IDLE);
                done_res_reg      <= done_next;
                rejected_reg      <= rejected_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign step_level    = step_level_reg;
    assign dir_level     = dir_level_reg;
    assign disable_lines = disable_lines_reg;
    assign busy_res      = busy_res_reg;
    assign done_res      = done_res_reg;
    assign rejected      = rejected_reg;

endmodule

FILE: design/rspg_checker.sv
// ----------------------------------------------------------------------------
// rspg_checker
// Port-level checks for the ramped stepper pulse generator, bound to the core.
// ----------------------------------------------------------------------------
module rspg_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic                               step_level,
    input  logic                               dir_level,
    input  logic [rspg_pkg::DISABLE_W-1:0]     disable_lines,
    input  logic                               busy_res,
    input  logic                               done_res,
    input  logic                               rejected
);

    a_done_ends_move: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && done_res) |-> (!busy_res && !rejected))
        else $error("done reported while still busy or rejecting");

    a_reject_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && rejected) |-> busy_res)
        else $error("start rejected while idle");

    a_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !busy_res) |->
            (!step_level && (disable_lines == rspg_pkg::ALL_DISABLED)))
        else $error("step line high or motor enabled while idle");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(step_level) && $stable(dir_level) &&
             $stable(disable_lines) && $stable(busy_res) &&
             $stable(done_res) && $stable(rejected)))
        else $error("stalled result changed");

endmodule

bind ramped_stepper_pulse_generator_core rspg_checker u_rspg_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .step_level    (step_level),
    .dir_level     (dir_level),
    .disable_lines (disable_lines),
    .busy_res      (busy_res),
    .done_res      (done_res),
    .rejected      (rejected)
);
